// ===== rtl/bads_pkg.sv =====
`timescale 1ns / 1ps
package bads_pkg;

    localparam int CH_W       = 8;
    localparam int SUM_W      = 16;
    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int SCALE_W    = 5;
    localparam int PH_W       = 4;
    localparam int WT_W       = 5;
    localparam int RCP_W      = 25;
    localparam int RCP_SH     = 24;
    localparam int PROD_W     = SUM_W + RCP_W;
    localparam int MAX_SHRINK = 16;
    localparam int MAX_DIM    = 4096;
    localparam int IDX_W      = 4;
    localparam int CFG_DW     = 13;
    localparam int OQ_DEPTH   = 8;
    localparam int OQ_AW      = 3;
    localparam int OQ_CNT_W   = 4;
    localparam int OQ_LIMIT   = 4;
    localparam int DIV_STEPS  = 13;
    localparam int DIV_CNT_W  = 4;
    localparam int NLANE      = 3;

    typedef logic [CH_W-1:0] samp_t;

    typedef enum logic [IDX_W-1:0] {
        REG_SCALE  = 4'd0,
        REG_WIDTH  = 4'd1,
        REG_HEIGHT = 4'd2,
        REG_MODE   = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SCALE_W-1:0] s_eff;
        logic [POS_W-1:0]   wm1;
        logic [POS_W-1:0]   hm1;
        logic [PH_W-1:0]    pad_w;
        logic [PH_W-1:0]    pad_h;
        logic [POS_W-1:0]   q_col;
        logic [PH_W-1:0]    r_col;
        logic               color;
    } bads_geom_t;

    typedef struct packed {
        logic             take;
        logic             cph_zero;
        logic [WT_W-1:0]  hw;
        logic             col_done;
        logic [POS_W-1:0] ocol;
        logic [WT_W-1:0]  vw;
        logic             rzero;
        logic             res;
        logic             row_end;
        logic             frame_end;
    } bads_lane_in_t;

    typedef struct packed {
        logic valid;
        logic row_end;
        logic frame_end;
    } bads_flag_t;

    typedef struct packed {
        samp_t avg_a;
        samp_t avg_b;
        samp_t avg_c;
        logic  row_end;
        logic  frame_end;
    } bads_res_t;

    // ceil(2^24 / (s*s)): exact floor division of a 16-bit sum for s up to 16
    function automatic logic [RCP_W-1:0] recip(input logic [SCALE_W-1:0] s);
        logic [RCP_W-1:0] r;
        case (s)
            5'd1:    r = 25'd16777216;
            5'd2:    r = 25'd4194304;
            5'd3:    r = 25'd1864136;
            5'd4:    r = 25'd1048576;
            5'd5:    r = 25'd671089;
            5'd6:    r = 25'd466034;
            5'd7:    r = 25'd342393;
            5'd8:    r = 25'd262144;
            5'd9:    r = 25'd207127;
            5'd10:   r = 25'd167773;
            5'd11:   r = 25'd138655;
            5'd12:   r = 25'd116509;
            5'd13:   r = 25'd99274;
            5'd14:   r = 25'd85599;
            5'd15:   r = 25'd74566;
            default: r = 25'd65536;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bads_if.sv =====
`timescale 1ns / 1ps
interface bads_pix_if import bads_pkg::*; ();
    logic  valid;
    logic  ready;
    samp_t chan_a;
    samp_t chan_b;
    samp_t chan_c;
    modport source (output valid, chan_a, chan_b, chan_c, input ready);
    modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface bads_res_if import bads_pkg::*; ();
    logic  valid;
    logic  ready;
    samp_t avg_a;
    samp_t avg_b;
    samp_t avg_c;
    logic  row_end;
    logic  frame_end;
    modport source (output valid, avg_a, avg_b, avg_c, row_end, frame_end, input ready);
    modport sink   (input valid, avg_a, avg_b, avg_c, row_end, frame_end, output ready);
endinterface

interface bads_cfg_if import bads_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  index;
    logic [CFG_DW-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/bads_cfg.sv =====
`timescale 1ns / 1ps
module bads_cfg import bads_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    bads_cfg_if.sink         cfg,
    input  logic [POS_W-1:0] col_pos,
    output bads_geom_t       geom
);

    logic [SCALE_W-1:0]   scale_reg, scale_next;
    logic [DIM_W-1:0]     width_reg, width_next;
    logic [DIM_W-1:0]     height_reg, height_next;
    logic                 mode_reg, mode_next;
    logic                 pend_reg, pend_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIM_W-1:0]     shw_reg, shw_next;
    logic [DIM_W-1:0]     shh_reg, shh_next;
    logic [DIM_W-1:0]     shc_reg, shc_next;
    logic [PH_W-1:0]      rw_reg, rw_next;
    logic [PH_W-1:0]      rh_reg, rh_next;
    logic [PH_W-1:0]      rc_reg, rc_next;

    logic [SCALE_W-1:0] s_eff;
    logic [DIM_W-1:0]   w_eff, h_eff;
    logic [SCALE_W-1:0] tw, th, tc;
    logic               gw, gh, gc;
    logic               wr;

    assign cfg.ready = 1'b1;
    assign wr = cfg.valid;

    always_comb
    begin
        if (scale_reg == '0)
            s_eff = SCALE_W'(1);
        else if (scale_reg > SCALE_W'(MAX_SHRINK))
            s_eff = SCALE_W'(MAX_SHRINK);
        else
            s_eff = scale_reg;
        if (width_reg == '0)
            w_eff = DIM_W'(1);
        else if (width_reg > DIM_W'(MAX_DIM))
            w_eff = DIM_W'(MAX_DIM);
        else
            w_eff = width_reg;
        if (height_reg == '0)
            h_eff = DIM_W'(1);
        else if (height_reg > DIM_W'(MAX_DIM))
            h_eff = DIM_W'(MAX_DIM);
        else
            h_eff = height_reg;
    end

    // one restoring step per cycle on all three dividends while busy and no write arrives
    assign tw = {rw_reg, shw_reg[DIM_W-1]};
    assign th = {rh_reg, shh_reg[DIM_W-1]};
    assign tc = {rc_reg, shc_reg[DIM_W-1]};
    assign gw = tw >= s_eff;
    assign gh = th >= s_eff;
    assign gc = tc >= s_eff;

    always_comb
    begin
        scale_next  = scale_reg;
        width_next  = width_reg;
        height_next = height_reg;
        mode_next   = mode_reg;
        pend_next   = pend_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        shw_next    = shw_reg;
        shh_next    = shh_reg;
        shc_next    = shc_reg;
        rw_next     = rw_reg;
        rh_next     = rh_reg;
        rc_next     = rc_reg;
        if (wr)
        begin
            pend_next = 1'b1;
            busy_next = 1'b0;
            unique case (cfg.index)
                REG_SCALE:  scale_next  = cfg.data[SCALE_W-1:0];
                REG_WIDTH:  width_next  = cfg.data;
                REG_HEIGHT: height_next = cfg.data;
                REG_MODE:   mode_next   = cfg.data[0];
                default:    ;
            endcase
        end
        else if (pend_reg)
        begin
            pend_next = 1'b0;
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            shw_next  = w_eff;
            shh_next  = h_eff;
            shc_next  = {1'b0, col_pos};
            rw_next   = '0;
            rh_next   = '0;
            rc_next   = '0;
        end
        else if (busy_reg)
        begin
            rw_next  = gw ? PH_W'(tw - s_eff) : tw[PH_W-1:0];
            rh_next  = gh ? PH_W'(th - s_eff) : th[PH_W-1:0];
            rc_next  = gc ? PH_W'(tc - s_eff) : tc[PH_W-1:0];
            shw_next = {shw_reg[DIM_W-2:0], 1'b0};
            shh_next = {shh_reg[DIM_W-2:0], 1'b0};
            shc_next = {shc_reg[DIM_W-2:0], gc};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            mode_reg   <= 1'b0;
            pend_reg   <= 1'b0;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
            shw_reg    <= '0;
            shh_reg    <= '0;
            shc_reg    <= '0;
            rw_reg     <= '0;
            rh_reg     <= '0;
            rc_reg     <= '0;
        end
        else
        begin
            scale_reg  <= scale_next;
            width_reg  <= width_next;
            height_reg <= height_next;
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            busy_reg   <= busy_next;
            done_reg   <= done_next;
            cnt_reg    <= cnt_next;
            shw_reg    <= shw_next;
            shh_reg    <= shh_next;
            shc_reg    <= shc_next;
            rw_reg     <= rw_next;
            rh_reg     <= rh_next;
            rc_reg     <= rc_next;
        end
    end

    always_comb
    begin
        geom.busy  = pend_reg | busy_reg | done_reg;
        geom.done  = done_reg;
        geom.s_eff = s_eff;
        geom.wm1   = POS_W'(w_eff - DIM_W'(1));
        geom.hm1   = POS_W'(h_eff - DIM_W'(1));
        geom.pad_w = (rw_reg == '0) ? '0 : PH_W'(s_eff - {1'b0, rw_reg});
        geom.pad_h = (rh_reg == '0) ? '0 : PH_W'(s_eff - {1'b0, rh_reg});
        geom.q_col = shc_reg[POS_W-1:0];
        geom.r_col = rc_reg;
        geom.color = mode_reg;
    end

endmodule

// ===== rtl/bads_lane.sv =====
`timescale 1ns / 1ps
module bads_lane import bads_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  bads_lane_in_t      li,
    input  samp_t              samp,
    input  logic               lane_on,
    input  logic [SCALE_W-1:0] s_eff,
    output samp_t              avg,
    output bads_flag_t         flag
);

    logic [SUM_W-1:0] band_mem [MAX_DIM];

    logic [SUM_W-1:0]  grp_reg;
    logic              v1_reg, v2_reg, v3_reg;
    logic [POS_W-1:0]  oc1_reg;
    logic [SUM_W-1:0]  gs1_reg;
    logic [WT_W-1:0]   vw1_reg;
    logic              rz1_reg, res1_reg;
    logic              re1_reg, fe1_reg, re2_reg, fe2_reg, re3_reg, fe3_reg;
    logic [SUM_W-1:0]  rd_reg;
    logic              wv_reg;
    logic [POS_W-1:0]  woc_reg;
    logic [SUM_W-1:0]  wdat_reg;
    logic [SUM_W-1:0]  sum2_reg;
    logic [PROD_W-1:0] prod3_reg;

    samp_t                   samp_m;
    logic [CH_W+WT_W-1:0]    hprod;
    logic [SUM_W-1:0]        gs_new;
    logic [SUM_W-1:0]        bsrc;
    logic [SUM_W+WT_W-1:0]   vprod;
    logic [SUM_W-1:0]        nsum;
    logic [PROD_W-1:0]       prod;
    logic [PROD_W-RCP_SH-1:0] quo;

    assign samp_m = lane_on ? samp : '0;
    assign hprod  = samp_m * li.hw;
    assign gs_new = (li.cph_zero ? '0 : grp_reg) + SUM_W'(hprod);

    // one-deep forward covers a band entry written by the beat just ahead
    assign bsrc  = rz1_reg ? '0 : ((wv_reg && woc_reg == oc1_reg) ? wdat_reg : rd_reg);
    assign vprod = gs1_reg * vw1_reg;
    assign nsum  = bsrc + vprod[SUM_W-1:0];
    assign prod  = sum2_reg * recip(s_eff);
    assign quo   = prod3_reg[PROD_W-1:RCP_SH];

    always_ff @(posedge clk)
    begin
        if (li.take && li.col_done)
            rd_reg <= band_mem[li.ocol];
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
            band_mem[oc1_reg] <= nsum;
    end

    always_ff @(posedge clk)
    begin
        oc1_reg   <= li.ocol;
        gs1_reg   <= gs_new;
        vw1_reg   <= li.vw;
        rz1_reg   <= li.rzero;
        re1_reg   <= li.row_end;
        fe1_reg   <= li.frame_end;
        woc_reg   <= oc1_reg;
        wdat_reg  <= nsum;
        sum2_reg  <= nsum;
        re2_reg   <= re1_reg;
        fe2_reg   <= fe1_reg;
        prod3_reg <= prod;
        re3_reg   <= re2_reg;
        fe3_reg   <= fe2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_reg  <= '0;
            v1_reg   <= 1'b0;
            res1_reg <= 1'b0;
            wv_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
        end
        else
        begin
            if (li.take)
                grp_reg <= gs_new;
            v1_reg   <= li.take & li.col_done;
            res1_reg <= li.res;
            wv_reg   <= v1_reg;
            v2_reg   <= v1_reg & res1_reg;
            v3_reg   <= v2_reg;
        end
    end

    always_comb
    begin
        if (!lane_on)
            avg = '0;
        else if (quo > (PROD_W-RCP_SH)'(255))
            avg = 8'd255;
        else
            avg = quo[CH_W-1:0];
        flag.valid     = v3_reg;
        flag.row_end   = re3_reg;
        flag.frame_end = fe3_reg;
    end

endmodule

// ===== rtl/bads_outq.sv =====
`timescale 1ns / 1ps
module bads_outq import bads_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  bads_res_t  din,
    bads_res_if.source res,
    output logic       space
);

    bads_res_t q_mem [OQ_DEPTH];

    logic [OQ_AW-1:0]    wp_reg, wp_next;
    logic [OQ_AW-1:0]    rp_reg, rp_next;
    logic [OQ_CNT_W-1:0] cnt_reg, cnt_next;
    logic                pop;
    bads_res_t           head;

    assign pop  = res.valid & res.ready;
    assign head = q_mem[rp_reg];

    always_comb
    begin
        wp_next  = push ? wp_reg + OQ_AW'(1) : wp_reg;
        rp_next  = pop ? rp_reg + OQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg + OQ_CNT_W'(push) - OQ_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_comb
    begin
        res.valid     = cnt_reg != '0;
        res.avg_a     = head.avg_a;
        res.avg_b     = head.avg_b;
        res.avg_c     = head.avg_c;
        res.row_end   = head.row_end;
        res.frame_end = head.frame_end;
        space         = cnt_reg <= OQ_CNT_W'(OQ_LIMIT);
    end

endmodule

// ===== rtl/box_average_downscaler_core.sv =====
`timescale 1ns / 1ps
// Box-average downscaler: raster pixels in, one pixel per clock while the port is ready, each
// S x S block averaged per channel by three channel lanes with a 4096-entry band memory each;
// an averaged pixel passes the lane's accumulate, sum and product registers into an
// eight-deep result queue that keeps pixel intake going while the sink stalls, and intake
// pauses when that queue holds more than four results or while the geometry unit is busy.
// After the last configuration write a 13-step remainder and quotient unit runs (edge padding
// and current output column), and the pixel port is held off until its results are loaded.
module box_average_downscaler_core import bads_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    bads_pix_if.sink   pix,
    bads_res_if.source res,
    bads_cfg_if.sink   cfg
);

    bads_geom_t    geom;
    bads_lane_in_t li;
    samp_t         lane_samp [NLANE];
    samp_t         lane_avg  [NLANE];
    bads_flag_t    lane_flag [NLANE];
    bads_res_t     qin;
    logic          space;
    logic          take;

    logic [POS_W-1:0] col_reg, col_next;
    logic [POS_W-1:0] row_reg, row_next;
    logic [PH_W-1:0]  cph_reg, cph_next;
    logic [PH_W-1:0]  rph_reg, rph_next;
    logic [POS_W-1:0] oc_reg, oc_next;
    logic [PH_W-1:0]  omod_reg, omod_next;

    logic [SCALE_W-1:0] s_m1;
    logic [SCALE_W-1:0] omod_inc;
    logic               last_col, last_row, col_done, row_done;

    bads_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .col_pos (col_reg),
        .geom    (geom)
    );

    assign pix.ready = !geom.busy && space;
    assign take      = pix.valid & pix.ready;

    assign s_m1     = geom.s_eff - SCALE_W'(1);
    assign omod_inc = {1'b0, omod_reg} + SCALE_W'(1);
    assign last_col = col_reg >= geom.wm1;
    assign last_row = row_reg >= geom.hm1;
    assign col_done = last_col || ({1'b0, cph_reg} >= s_m1);
    assign row_done = last_row || ({1'b0, rph_reg} >= s_m1);

    always_comb
    begin
        li.take      = take;
        li.cph_zero  = cph_reg == '0;
        li.hw        = last_col ? {1'b0, geom.pad_w} + WT_W'(1) : WT_W'(1);
        li.col_done  = col_done;
        li.ocol      = oc_reg;
        li.vw        = last_row ? {1'b0, geom.pad_h} + WT_W'(1) : WT_W'(1);
        li.rzero     = rph_reg == '0;
        li.res       = row_done;
        li.row_end   = last_col;
        li.frame_end = last_col & last_row;
    end

    always_comb
    begin
        col_next  = col_reg;
        row_next  = row_reg;
        cph_next  = cph_reg;
        rph_next  = rph_reg;
        oc_next   = oc_reg;
        omod_next = omod_reg;
        if (geom.done)
        begin
            oc_next   = geom.q_col;
            omod_next = geom.r_col;
        end
        else if (take)
        begin
            if (last_col)
            begin
                col_next  = '0;
                cph_next  = '0;
                oc_next   = '0;
                omod_next = '0;
                if (last_row)
                begin
                    row_next = '0;
                    rph_next = '0;
                end
                else
                begin
                    row_next = row_reg + POS_W'(1);
                    rph_next = row_done ? '0 : rph_reg + PH_W'(1);
                end
            end
            else
            begin
                col_next = col_reg + POS_W'(1);
                cph_next = col_done ? '0 : cph_reg + PH_W'(1);
                if (omod_inc == geom.s_eff)
                begin
                    oc_next   = oc_reg + POS_W'(1);
                    omod_next = '0;
                end
                else
                    omod_next = omod_inc[PH_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            cph_reg  <= '0;
            rph_reg  <= '0;
            oc_reg   <= '0;
            omod_reg <= '0;
        end
        else
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            cph_reg  <= cph_next;
            rph_reg  <= rph_next;
            oc_reg   <= oc_next;
            omod_reg <= omod_next;
        end
    end

    assign lane_samp[0] = pix.chan_a;
    assign lane_samp[1] = pix.chan_b;
    assign lane_samp[2] = pix.chan_c;

    for (genvar i = 0; i < NLANE; i++)
    begin : g_lane
        bads_lane u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .li      (li),
            .samp    (lane_samp[i]),
            .lane_on ((i == 0) || geom.color),
            .s_eff   (geom.s_eff),
            .avg     (lane_avg[i]),
            .flag    (lane_flag[i])
        );
    end

    always_comb
    begin
        qin.avg_a     = lane_avg[0];
        qin.avg_b     = lane_avg[1];
        qin.avg_c     = lane_avg[2];
        qin.row_end   = lane_flag[0].row_end;
        qin.frame_end = lane_flag[0].frame_end;
    end

    bads_outq u_outq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (lane_flag[0].valid),
        .din   (qin),
        .res   (res),
        .space (space)
    );

`ifndef ASSERT_OFF
    a_frame_end_row_end: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (!res.frame_end || res.row_end))
        else $error("frame end without row end");

    a_omod_range: assert property (@(posedge clk) disable iff (!rst_n)
        !geom.busy |-> ({1'b0, omod_reg} < geom.s_eff))
        else $error("output column phase out of range");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (take && last_col && last_row) |=> (col_reg == '0 && row_reg == '0))
        else $error("position not cleared at frame end");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    import bads_pkg::*;

    logic clk;
    logic rst_n;

    bads_pix_if pix ();
    bads_res_if res ();
    bads_cfg_if cfg ();

    box_average_downscaler_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix.sink),
        .res   (res.source),
        .cfg   (cfg.sink)
    );

    typedef struct {
        samp_t a;
        samp_t b;
        samp_t c;
        logic  re;
        logic  fe;
    } avg_pix_t;

    typedef struct {
        samp_t a;
        samp_t b;
        samp_t c;
        logic  chk;
        samp_t ea;
        logic  ere;
        logic  efe;
    } stim_row_t;

    // predictor state
    logic [15:0] band_acc [MAX_DIM][3];
    logic [15:0] run_acc [3];
    int unsigned col_at, row_at, col_ph, row_ph;
    int unsigned shrink_reg, wid_reg, hgt_reg, rgb_reg;

    avg_pix_t pending_avgs[$];
    int fails;
    int beats_in;
    int beats_out;
    bit sink_hold;

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int unsigned clamp_size(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    function automatic int unsigned pad_of(int unsigned d, int unsigned s);
        return (d % s == 0) ? 0 : s - d % s;
    endfunction

    function automatic void predict_downscale(samp_t ia, samp_t ib, samp_t ic);
        int unsigned s, w, h, hw, vw, oc, v, g, bsum;
        int unsigned smp [3];
        logic lc, lr, cd, rd;
        avg_pix_t p;
        s = shrink_reg;
        if (s == 0) s = 1;
        if (s > MAX_SHRINK) s = MAX_SHRINK;
        w = clamp_size(wid_reg);
        h = clamp_size(hgt_reg);
        smp[0] = ia;
        smp[1] = rgb_reg ? ib : 0;
        smp[2] = rgb_reg ? ic : 0;
        lc = col_at >= w - 1;
        lr = row_at >= h - 1;
        cd = lc || col_ph >= s - 1;
        rd = lr || row_ph >= s - 1;
        hw = lc ? 1 + pad_of(w, s) : 1;
        vw = lr ? 1 + pad_of(h, s) : 1;
        for (int c = 0; c < 3; c++)
        begin
            g = (col_ph == 0) ? 0 : run_acc[c];
            run_acc[c] = 16'(g + smp[c] * hw);
        end
        if (cd)
        begin
            oc = col_at / s;
            if (oc >= MAX_DIM) oc = MAX_DIM - 1;
            for (int c = 0; c < 3; c++)
            begin
                bsum = (row_ph == 0) ? 0 : band_acc[oc][c];
                band_acc[oc][c] = 16'(bsum + run_acc[c] * vw);
            end
            if (rd)
            begin
                v = band_acc[oc][0] / (s * s);
                p.a = (v > 255) ? 8'd255 : 8'(v);
                v = band_acc[oc][1] / (s * s);
                p.b = !rgb_reg ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                v = band_acc[oc][2] / (s * s);
                p.c = !rgb_reg ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
                p.re = lc;
                p.fe = lc && lr;
                pending_avgs.push_back(p);
            end
        end
        if (lc)
        begin
            col_at = 0;
            col_ph = 0;
            if (lr)
            begin
                row_at = 0;
                row_ph = 0;
            end
            else
            begin
                row_at++;
                row_ph = rd ? 0 : row_ph + 1;
            end
        end
        else
        begin
            col_at++;
            col_ph = cd ? 0 : col_ph + 1;
        end
    endfunction

    // result sink: random stalls, check at rising edge
    initial
    begin
        res.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!sink_hold && $urandom_range(0, 60) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(10, 40)) @(negedge clk);
            end
            else if (sink_hold || $urandom_range(0, 3) != 0)
                res.ready <= 1'b1;
            else
                res.ready <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res.valid && res.ready)
        begin
            beats_out++;
            if (pending_avgs.size() == 0)
            begin
                $error("unexpected result beat");
                fails++;
            end
            else
            begin
                avg_pix_t e;
                e = pending_avgs.pop_front();
                if (res.avg_a !== e.a)
                begin
                    $error("avg_a exp %0d got %0d", e.a, res.avg_a);
                    fails++;
                end
                if (res.avg_b !== e.b)
                begin
                    $error("avg_b exp %0d got %0d", e.b, res.avg_b);
                    fails++;
                end
                if (res.avg_c !== e.c)
                begin
                    $error("avg_c exp %0d got %0d", e.c, res.avg_c);
                    fails++;
                end
                if (res.row_end !== e.re)
                begin
                    $error("row_end exp %0b got %0b", e.re, res.row_end);
                    fails++;
                end
                if (res.frame_end !== e.fe)
                begin
                    $error("frame_end exp %0b got %0b", e.fe, res.frame_end);
                    fails++;
                end
            end
        end
    end

    task automatic write_reg(cfg_reg_t idx, int unsigned val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= CFG_DW'(val);
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            REG_SCALE:  shrink_reg = val & 5'h1f;
            REG_WIDTH:  wid_reg = val & 13'h1fff;
            REG_HEIGHT: hgt_reg = val & 13'h1fff;
            default:    rgb_reg = val & 1;
        endcase
        @(negedge clk);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        sink_hold = 1'b1;
        while (pending_avgs.size() != 0 && guard < 200000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (20) @(negedge clk);
        sink_hold = 1'b0;
    endtask

    task automatic set_geometry(int unsigned s, int unsigned w, int unsigned h, int unsigned m);
        wait_drained();
        write_reg(REG_SCALE, s);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MODE, m);
        cfg.valid <= 1'b0;
    endtask

    // one pixel beat; gaps random before it
    task automatic send_pixel(samp_t a, samp_t b, samp_t c, bit gaps);
        if (gaps && $urandom_range(0, 4) == 0)
        begin
            pix.valid <= 1'b0;
            if ($urandom_range(0, 15) == 0)
                repeat ($urandom_range(5, 30)) @(negedge clk);
            else
                repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        pix.valid  <= 1'b1;
        pix.chan_a <= a;
        pix.chan_b <= b;
        pix.chan_c <= c;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        predict_downscale(a, b, c);
        beats_in++;
        @(negedge clk);
    endtask

    task automatic send_frame(int unsigned w, int unsigned h, int kind);
        samp_t a, b, c;
        for (int i = 0; i < clamp_size(w) * clamp_size(h); i++)
        begin
            a = kind == 1 ? 8'hff : kind == 2 ? 8'h00 : 8'($urandom);
            b = kind == 1 ? 8'hff : kind == 2 ? 8'h00 : 8'($urandom);
            c = kind == 1 ? 8'hff : kind == 2 ? 8'h00 : 8'($urandom);
            send_pixel(a, b, c, 1'b1);
        end
        pix.valid <= 1'b0;
    endtask

    stim_row_t plan [$];

    initial
    begin
        int unsigned s, w, h;
        fails = 0;
        beats_in = 0;
        beats_out = 0;
        sink_hold = 1'b0;
        shrink_reg = 1;
        wid_reg = 1;
        hgt_reg = 1;
        rgb_reg = 0;
        col_at = 0;
        row_at = 0;
        col_ph = 0;
        row_ph = 0;
        for (int c = 0; c < 3; c++) run_acc[c] = '0;
        pix.valid = 1'b0;
        pix.chan_a = '0;
        pix.chan_b = '0;
        pix.chan_c = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        repeat (20) @(negedge clk);

        // after reset: 1x1 frame at scale 1 in gray mode, each pixel's first channel passes straight through
        plan = '{
            '{8'h00, 8'h11, 8'h22, 1'b1, 8'h00, 1'b1, 1'b1},
            '{8'hff, 8'hff, 8'hff, 1'b1, 8'hff, 1'b1, 1'b1},
            '{8'h5a, 8'ha5, 8'h3c, 1'b1, 8'h5a, 1'b1, 1'b1},
            '{8'h80, 8'h01, 8'h7f, 1'b0, 8'h00, 1'b0, 1'b0}
        };
        foreach (plan[i])
        begin
            if (plan[i].chk)
            begin
                predict_downscale(plan[i].a, plan[i].b, plan[i].c);
                void'(pending_avgs.pop_back());
                pending_avgs.push_back('{plan[i].ea, 8'h00, 8'h00, plan[i].ere, plan[i].efe});
                col_at = 0;
                row_at = 0;
                col_ph = 0;
                row_ph = 0;
                send_direct(plan[i]);
            end
            else
                send_pixel(plan[i].a, plan[i].b, plan[i].c, 1'b0);
        end
        pix.valid <= 1'b0;

        // extremes: zero/oversize scale, zero sizes, padding, full-scale samples
        set_geometry(0, 3, 2, 1);
        send_frame(3, 2, 0);
        set_geometry(31, 17, 3, 1);
        send_frame(17, 3, 1);
        set_geometry(16, 16, 2, 0);
        send_frame(16, 2, 2);
        set_geometry(5, 0, 0, 1);
        send_frame(1, 1, 1);
        set_geometry(3, 7, 5, 1);
        send_frame(7, 5, 0);
        set_geometry(2, 301, 1, 1);
        send_frame(301, 1, 0);

        // random frames, mostly small
        while (beats_in < 1100)
        begin
            s = $urandom_range(0, 20);
            if ($urandom_range(0, 9) == 0)
            begin
                w = $urandom_range(1, 200);
                h = $urandom_range(1, 2);
            end
            else
            begin
                w = $urandom_range(1, 16);
                h = $urandom_range(1, 16);
            end
            set_geometry(s, w, h, $urandom_range(0, 1));
            send_frame(w, h, $urandom_range(0, 7) == 0 ? $urandom_range(1, 2) : 0);
        end

        wait_drained();
        repeat (50) @(negedge clk);
        $display("%0d pixel beats in, %0d averaged pixels out, scales 1..16, gray and RGB,",
                 beats_in, beats_out);
        $display("padded edges, clamped register values and sink stalls exercised");
        if (fails == 0 && pending_avgs.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    task automatic send_direct(stim_row_t r);
        send_pixel(r.a, r.b, r.c, 1'b0);
        // send_pixel already advanced the predictor; undo that second step
        void'(pending_avgs.pop_back());
        col_at = 0;
        row_at = 0;
        col_ph = 0;
        row_ph = 0;
    endtask

    initial
    begin
        #(80_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
